/* sv/lgs_pkg.sv */
// Shared constants and operation codes for the life grid generation step block.
package lgs_pkg;

	localparam int GRID_W = 128;
	localparam int GRID_H = 128;
	localparam int X_W    = $clog2(GRID_W);
	localparam int Y_W    = $clog2(GRID_H);
	localparam int RA_W   = Y_W + 1;
	localparam int MEM_D  = 2 * GRID_H;
	localparam int AW_W   = 8;
	localparam int OP_W   = 2;
	localparam int CNT_W  = 4;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_GEN   = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD   = 2'd3;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [AW_W-1:0] WIDTH_RST  = AW_W'(GRID_W);
	localparam logic [AW_W-1:0] HEIGHT_RST = AW_W'(GRID_H);

	typedef logic [GRID_W-1:0] row_t;

endpackage

/* sv/life_grid_generation_step.sv */
// Life grid with cell read/write and B3/S23 generation step over row-wide ping-pong banks.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | s_tuser opcode; s_tdata col_x,row_y,alive
//  m_      | out | m_tvalid / m_tready   | m_tuser kind,out_of_range; m_tdata read_alive
//  apb     | in  | psel,penable,pwrite   | paddr, pwdata, prdata (active width/height)
//
//  Read or write: the request steps through states CRD, CWR and DONE to its result;
//  an out-of-range or invalid request goes from IDLE to DONE. Generation uses the
//  single neighbor-count unit, visiting one cell per cycle from a three-row window.
//  After reset a clearing pass zeroes the 2*GRID_H rows of both banks; s_tready is low.
//  A stalled result holds in the output register; the next request is taken meanwhile.
module life_grid_generation_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // col_x[6:0], row_y[13:7], cell_alive[14], zero[15]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // read_alive[0], zero[7:1]
	output logic [2:0]  m_tuser,   // result_kind[1:0], out_of_range[2]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CRD  = 4'd2;
	localparam logic [3:0] ST_CWR  = 4'd3;
	localparam logic [3:0] ST_G0RD = 4'd4;
	localparam logic [3:0] ST_G0LD = 4'd5;
	localparam logic [3:0] ST_RRD  = 4'd6;
	localparam logic [3:0] ST_RLD  = 4'd7;
	localparam logic [3:0] ST_CELL = 4'd8;
	localparam logic [3:0] ST_RWR  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam logic [lgs_pkg::X_W-1:0] X_LAST = lgs_pkg::X_W'(lgs_pkg::GRID_W - 1);
	localparam logic [lgs_pkg::Y_W-1:0] Y_LAST = lgs_pkg::Y_W'(lgs_pkg::GRID_H - 1);
	localparam logic [lgs_pkg::RA_W-1:0] CLR_LAST = lgs_pkg::RA_W'(lgs_pkg::MEM_D - 1);

	logic [3:0]                  state_q;
	logic [lgs_pkg::RA_W-1:0]    clr_q;
	logic                        bank_q;
	logic [lgs_pkg::AW_W-1:0]    width_q;
	logic [lgs_pkg::AW_W-1:0]    height_q;
	logic [lgs_pkg::OP_W-1:0]    op_q;
	logic [lgs_pkg::X_W-1:0]     x_q;
	logic [lgs_pkg::Y_W-1:0]     y_q;
	logic                        val_q;
	logic [lgs_pkg::OP_W-1:0]    res_kind_q;
	logic                        res_rd_q;
	logic                        res_oor_q;
	logic                        out_valid_q;
	logic [lgs_pkg::OP_W-1:0]    out_kind_q;
	logic                        out_rd_q;
	logic                        out_oor_q;

	lgs_pkg::row_t               grid_mem_q [lgs_pkg::MEM_D];
	lgs_pkg::row_t               rdata_q;
	lgs_pkg::row_t               prev_q;
	lgs_pkg::row_t               cur_q;
	lgs_pkg::row_t               next_q;
	lgs_pkg::row_t               new_q;

	logic [lgs_pkg::AW_W-1:0]    w_eff;
	logic [lgs_pkg::AW_W-1:0]    h_eff;
	lgs_pkg::row_t               col_mask;
	logic [lgs_pkg::OP_W-1:0]    in_op;
	logic [lgs_pkg::X_W-1:0]     in_x;
	logic [lgs_pkg::Y_W-1:0]     in_y;
	logic                        in_inside;
	logic                        in_oor;
	logic                        accept;
	logic                        cfg_we;

	logic                        mem_we;
	logic [lgs_pkg::RA_W-1:0]    mem_waddr;
	lgs_pkg::row_t               mem_wdata;
	logic [lgs_pkg::RA_W-1:0]    mem_raddr;
	lgs_pkg::row_t               cell_row;

	logic [lgs_pkg::X_W-1:0]     xm;
	logic [lgs_pkg::X_W-1:0]     xp;
	logic                        has_l;
	logic                        has_r;
	logic [lgs_pkg::CNT_W-1:0]   ncount;
	logic                        cell_in;
	logic                        new_bit;
	logic [lgs_pkg::AW_W-1:0]    next_y;
	logic                        next_row_ok;
	logic                        first_row_ok;
	logic                        out_free;

	// effective area and column mask
	always_comb begin
		w_eff = (width_q  > lgs_pkg::AW_W'(lgs_pkg::GRID_W)) ? lgs_pkg::AW_W'(lgs_pkg::GRID_W)
			: width_q;
		h_eff = (height_q > lgs_pkg::AW_W'(lgs_pkg::GRID_H)) ? lgs_pkg::AW_W'(lgs_pkg::GRID_H)
			: height_q;
		for (int i = 0; i < lgs_pkg::GRID_W; i++) begin
			col_mask[i] = lgs_pkg::AW_W'(i) < w_eff;
		end
	end

	assign in_op     = s_tuser;
	assign in_x      = s_tdata[6:0];
	assign in_y      = s_tdata[13:7];
	assign in_inside = (lgs_pkg::AW_W'(in_x) < w_eff) && (lgs_pkg::AW_W'(in_y) < h_eff);
	assign in_oor    = (in_op == lgs_pkg::OP_BAD)
		|| (((in_op == lgs_pkg::OP_WRITE) || (in_op == lgs_pkg::OP_READ)) && !in_inside);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lgs_pkg::REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	// neighbor-count unit
	always_comb begin
		xm     = x_q - 1'b1;
		xp     = x_q + 1'b1;
		has_l  = (x_q != '0);
		has_r  = (x_q != X_LAST);
		ncount = lgs_pkg::CNT_W'(has_l && prev_q[xm]) + lgs_pkg::CNT_W'(prev_q[x_q])
			+ lgs_pkg::CNT_W'(has_r && prev_q[xp]) + lgs_pkg::CNT_W'(has_l && cur_q[xm])
			+ lgs_pkg::CNT_W'(has_r && cur_q[xp]) + lgs_pkg::CNT_W'(has_l && next_q[xm])
			+ lgs_pkg::CNT_W'(next_q[x_q]) + lgs_pkg::CNT_W'(has_r && next_q[xp]);
		cell_in = (lgs_pkg::AW_W'(x_q) < w_eff) && (lgs_pkg::AW_W'(y_q) < h_eff);
		if (cur_q[x_q]) begin
			new_bit = cell_in && ((ncount == lgs_pkg::CNT_W'(2)) || (ncount == lgs_pkg::CNT_W'(3)));
		end else begin
			new_bit = cell_in && (ncount == lgs_pkg::CNT_W'(3));
		end
		next_y       = lgs_pkg::AW_W'(y_q) + 1'b1;
		next_row_ok  = next_y < h_eff;
		first_row_ok = (h_eff != '0);
	end

	// memory port selection
	always_comb begin
		cell_row        = rdata_q;
		cell_row[x_q]   = val_q;
		mem_we          = 1'b0;
		mem_waddr       = clr_q;
		mem_wdata       = '0;
		mem_raddr       = {bank_q, y_q};
		unique case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_CWR: begin
				mem_we    = (op_q == lgs_pkg::OP_WRITE);
				mem_waddr = {bank_q, y_q};
				mem_wdata = cell_row;
			end
			ST_G0RD: begin
				mem_raddr = {bank_q, lgs_pkg::Y_W'(0)};
			end
			ST_RRD: begin
				mem_raddr = {bank_q, y_q + 1'b1};
			end
			ST_RWR: begin
				mem_we    = 1'b1;
				mem_waddr = {~bank_q, y_q};
				mem_wdata = new_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= grid_mem_q[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			bank_q      <= 1'b0;
			width_q     <= lgs_pkg::WIDTH_RST;
			height_q    <= lgs_pkg::HEIGHT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (paddr[2] == lgs_pkg::REG_HEIGHT) begin
					height_q <= pwdata[lgs_pkg::AW_W-1:0];
				end else begin
					width_q <= pwdata[lgs_pkg::AW_W-1:0];
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (in_oor) begin
							state_q <= ST_DONE;
						end else if (in_op == lgs_pkg::OP_GEN) begin
							state_q <= ST_G0RD;
						end else begin
							state_q <= ST_CRD;
						end
					end
				end
				ST_CRD:  state_q <= ST_CWR;
				ST_CWR:  state_q <= ST_DONE;
				ST_G0RD: state_q <= ST_G0LD;
				ST_G0LD: state_q <= ST_RRD;
				ST_RRD:  state_q <= ST_RLD;
				ST_RLD:  state_q <= ST_CELL;
				ST_CELL: begin
					if (x_q == X_LAST) begin
						state_q <= ST_RWR;
					end
				end
				ST_RWR: begin
					if (y_q == Y_LAST) begin
						bank_q  <= ~bank_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RRD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q       <= in_op;
					x_q        <= in_x;
					y_q        <= in_y;
					val_q      <= s_tdata[14];
					res_kind_q <= in_op;
					res_rd_q   <= 1'b0;
					res_oor_q  <= in_oor;
				end
			end
			ST_CWR: begin
				if (op_q == lgs_pkg::OP_READ) begin
					res_rd_q <= rdata_q[x_q];
				end
			end
			ST_G0LD: begin
				prev_q <= '0;
				cur_q  <= first_row_ok ? (rdata_q & col_mask) : '0;
				y_q    <= '0;
			end
			ST_RLD: begin
				next_q <= next_row_ok ? (rdata_q & col_mask) : '0;
				x_q    <= '0;
			end
			ST_CELL: begin
				new_q[x_q] <= new_bit;
				x_q        <= x_q + 1'b1;
			end
			ST_RWR: begin
				prev_q <= cur_q;
				cur_q  <= next_q;
				y_q    <= y_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_kind_q <= res_kind_q;
					out_rd_q   <= res_rd_q;
					out_oor_q  <= res_oor_q;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_rd_q};
	assign m_tuser  = {out_oor_q, out_kind_q};

`ifndef ASSERT_OFF
	a_bank_flip_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> ($past(state_q) == ST_RWR))
		else $error("bank changed outside the last row write");

	a_gen_never_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == lgs_pkg::OP_GEN)) |-> !m_tuser[2])
		else $error("generation result flagged out of range");

	a_rd_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> ((m_tuser[1:0] == lgs_pkg::OP_READ) && !m_tuser[2]))
		else $error("cell value on a result that is not an in-range read");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the life grid block: a directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
	import lgs_pkg::*;

	localparam int GEN_CYCLES = GRID_H * (GRID_W + 3) + 4;
	localparam int STALL_LIMIT = 4 * GEN_CYCLES + 4 * MEM_D;
	localparam int PHASES = 9;
	localparam int PH_COLS [PHASES] = '{8, 1, 0, 12, 255, 16, 200, 5, 128};
	localparam int PH_ROWS [PHASES] = '{6, 1, 5, 0, 255, 12, 3, 128, 1};
	localparam int PH_ITEMS [PHASES] = '{70, 25, 20, 15, 60, 120, 40, 60, 40};
	localparam int CALM_PHASE = 5;

	typedef struct packed {
		logic [OP_W-1:0] kind;
		logic            alive;
		logic            oor;
	} grid_reply_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [X_W-1:0]  x;
		logic [Y_W-1:0]  y;
		logic            v;
		logic            fixed;
		grid_reply_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit [GRID_W-1:0]  cells [2][GRID_H];
	bit               live_bank;
	logic [AW_W-1:0]  reg_w;
	logic [AW_W-1:0]  reg_h;
	grid_reply_t      replies_due [$];
	plan_row_t        plan [$];
	bit               calm;
	int               errors;
	int               requests;
	int               generations;
	int               rejects;
	int               replies;
	int               settings;
	int               quiet;

	life_grid_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	function automatic int span(logic [AW_W-1:0] r, int lim);
		return (int'(r) > lim) ? lim : int'(r);
	endfunction

	function automatic void advance_life();
		int  cols;
		int  rows;
		int  n;
		int  nx;
		int  ny;
		bit  src;
		bit  nxt;
		cols = span(reg_w, GRID_W);
		rows = span(reg_h, GRID_H);
		src  = live_bank;
		for (int y = 0; y < GRID_H; y++) begin
			for (int x = 0; x < GRID_W; x++) begin
				nxt = 1'b0;
				if (x < cols && y < rows) begin
					n = 0;
					for (int dy = -1; dy <= 1; dy++) begin
						for (int dx = -1; dx <= 1; dx++) begin
							nx = x + dx;
							ny = y + dy;
							if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < cols && ny < rows)
								n += cells[src][ny][nx];
						end
					end
					nxt = cells[src][y][x] ? (n == 2 || n == 3) : (n == 3);
				end
				cells[!src][y][x] = nxt;
			end
		end
		live_bank = !src;
	endfunction

	function automatic grid_reply_t apply_request(logic [OP_W-1:0] op, logic [X_W-1:0] x,
			logic [Y_W-1:0] y, logic v);
		grid_reply_t r;
		bit          hit;
		hit     = int'(x) < span(reg_w, GRID_W) && int'(y) < span(reg_h, GRID_H);
		r.kind  = op;
		r.alive = 1'b0;
		r.oor   = 1'b0;
		case (op)
			OP_WRITE: begin
				if (hit)
					cells[live_bank][y][x] = v;
				else
					r.oor = 1'b1;
			end
			OP_READ: begin
				if (hit)
					r.alive = cells[live_bank][y][x];
				else
					r.oor = 1'b1;
			end
			OP_GEN: begin
				advance_life();
			end
			default: begin
				r.oor = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic void plan_row(logic [OP_W-1:0] op, int x, int y, logic v, logic fixed,
			logic [OP_W-1:0] kind, logic rd, logic oor);
		plan_row_t p;
		p.op    = op;
		p.x     = X_W'(x);
		p.y     = Y_W'(y);
		p.v     = v;
		p.fixed = fixed;
		p.want  = '{kind: kind, alive: rd, oor: oor};
		plan.push_back(p);
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y, input logic v, input logic fixed, input grid_reply_t want);
		grid_reply_t r;
		while (!calm && $urandom_range(0, 99) < 22) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, v, y, x};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		r = apply_request(op, x, y, v);
		replies_due.push_back(fixed ? want : r);
		requests++;
		if (op == OP_GEN)
			generations++;
		if (r.oor)
			rejects++;
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [0:0] idx, input logic [AW_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_grid(input logic [AW_W-1:0] w, input logic [AW_W-1:0] h);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		apb_write(REG_WIDTH, w);
		reg_w = w;
		apb_write(REG_HEIGHT, h);
		reg_h = h;
		settings++;
	endtask

	always @(negedge clk) begin
		m_tready <= calm || $urandom_range(0, 99) >= 22;
	end

	always @(posedge clk) begin
		grid_reply_t got;
		grid_reply_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind: m_tuser[1:0], alive: m_tdata[0], oor: m_tuser[2]};
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply kind %0d alive %0d oor %0d", $time,
					got.kind, got.alive, got.oor);
				errors++;
			end else begin
				exp = replies_due.pop_front();
				replies++;
				if (got !== exp) begin
					$display("%0t: reply mismatch: expected kind %0d alive %0d oor %0d, got kind %0d alive %0d oor %0d",
						$time, exp.kind, exp.alive, exp.oor, got.kind, got.alive, got.oor);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [OP_W-1:0] op;
		logic [X_W-1:0]  x;
		logic [Y_W-1:0]  y;
		int              cols;
		int              rows;
		int              pick;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		live_bank = 1'b0;
		reg_w     = WIDTH_RST;
		reg_h     = HEIGHT_RST;
		calm      = 1'b0;
		errors    = 0;
		quiet     = 0;

		plan_row(OP_READ,    0,   0, 1'b0, 1'b1, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,  127, 127, 1'b1, 1'b1, OP_READ,  1'b0, 1'b0);
		plan_row(OP_WRITE, 127, 127, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_READ,  127, 127, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_WRITE,   0,   0, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_WRITE,   1,   0, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_WRITE,   0,   1, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_WRITE, 127,  10, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_WRITE, 127,  11, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_WRITE, 127,  12, 1'b1, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_BAD,   127, 127, 1'b1, 1'b1, OP_BAD,   1'b0, 1'b1);
		plan_row(OP_GEN,    64,  64, 1'b1, 1'b1, OP_GEN,   1'b0, 1'b0);
		plan_row(OP_READ,  127,  11, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,  126,  11, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,  127,  10, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,    1,   1, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,  127, 127, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_WRITE,   1,   1, 1'b0, 1'b1, OP_WRITE, 1'b0, 1'b0);
		plan_row(OP_GEN,     0,   0, 1'b0, 1'b1, OP_GEN,   1'b0, 1'b0);
		plan_row(OP_READ,    1,   1, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);
		plan_row(OP_READ,    0,   0, 1'b0, 1'b0, OP_READ,  1'b0, 1'b0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_request(plan[i].op, plan[i].x, plan[i].y, plan[i].v, plan[i].fixed, plan[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_grid(AW_W'(PH_COLS[ph]), AW_W'(PH_ROWS[ph]));
			calm = (ph == CALM_PHASE);
			cols = span(reg_w, GRID_W);
			rows = span(reg_h, GRID_H);
			for (int n = 0; n < PH_ITEMS[ph]; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 44)
					op = OP_WRITE;
				else if (pick < 90)
					op = OP_READ;
				else if (pick < 95)
					op = OP_GEN;
				else
					op = OP_BAD;
				if (cols != 0 && rows != 0 && $urandom_range(0, 99) < 78) begin
					x = X_W'($urandom_range(0, cols - 1));
					y = Y_W'($urandom_range(0, rows - 1));
				end else begin
					x = X_W'($urandom_range(0, GRID_W - 1));
					y = Y_W'($urandom_range(0, GRID_H - 1));
				end
				send_request(op, x, y, 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end
		calm = 1'b0;
		set_grid(WIDTH_RST, HEIGHT_RST);

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d requests (%0d generations, %0d out of area or invalid) under %0d grid sizes.",
			requests, generations, rejects, settings);
		$display("Checked %0d replies, %0d mismatches.", replies, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
